// ===== rtl/core/zip_local_header_walker_macros.svh =====
// Assertion macros for the ZIP local header walker.
// Included by the top level; needs nothing else.
`ifndef ZIP_LOCAL_HEADER_WALKER_MACROS_SVH
`define ZIP_LOCAL_HEADER_WALKER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ZLHW_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define ZLHW_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/zlhw_pkg.sv =====
// Shared types, constants and codes for the ZIP local header walker.
// Used by every module in rtl/core; depends on nothing.
package zlhw_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    localparam logic [31:0] SIG_LOCAL = 32'h04034b50;
    localparam logic [31:0] SIG_EOCD  = 32'h06054b50;
    localparam logic [31:0] SIG_CDIR  = 32'h02014b50;
    localparam logic [31:0] SIG_DESC  = 32'h08074b50;

    localparam logic [15:0] FLAG_DESC = 16'h0008;
    localparam logic [15:0] FLAG_UTF8 = 16'h0800;

    localparam int HDR_LEN      = 30;
    localparam int HDR_AW       = $clog2(HDR_LEN);
    localparam int DESC_LEN     = 16;
    localparam int DESC_SIZE_AT = 8;
    localparam int SCAN_SIG_LEN = 4;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [2:0] ST_ENTRY   = 3'd0;
    localparam logic [2:0] ST_DIR     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_SHORT   = 3'd3;
    localparam logic [2:0] ST_METHOD  = 3'd4;
    localparam logic [2:0] ST_TRUNC   = 3'd5;
    localparam logic [2:0] ST_NODESC  = 3'd6;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_SCAN,
        PH_DTAIL,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_offset;
        logic [31:0] data_size;
        logic [15:0] name_length;
        logic        name_is_utf8;
        logic        finished;
    } result_t;

    typedef struct packed {
        logic             room;
        logic [OQ_AW:0]   level;
    } oq_stat_t;

endpackage

// ===== rtl/core/zip_local_header_walker.sv =====
// Top level of the ZIP local header walker: input register, parser, result queue.
// Depends on zlhw_pkg and zip_local_header_walker_macros.svh.
//
//   channel   handshake                  payload
//   byte      byte_valid / byte_stall    file_byte, end_of_file
//   result    result_valid / result_stall status, data_offset, data_size,
//                                        name_length, name_is_utf8, finished
//
// One byte request per cycle is taken while byte_stall is low; the parser
// handles each held byte once the queue has room, and its results reach the
// result port through the result queue. The queue sets the pace only when
// the result side stalls: the byte side stalls once fewer than two queue
// slots are free. Reset clears the parser, the input register's held flag and
// the queue; each archive starts over at offset 0 after its end_of_file byte.
module zip_local_header_walker
#(
    parameter int OFFSET_BITS = zlhw_pkg::OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [31:0] data_offset,
    output logic [31:0] data_size,
    output logic [15:0] name_length,
    output logic        name_is_utf8,
    output logic        finished
);

    zlhw_pkg::in_item_t  s1_item;
    zlhw_pkg::result_t   res0;
    zlhw_pkg::result_t   res1;
    zlhw_pkg::result_t   head;
    zlhw_pkg::oq_stat_t  oq_stat;
    logic                go;
    logic [1:0]          push_cnt;

    // Hold each byte request until the queue has room for two results.
    zlhw_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .room        (oq_stat.room),
        .go          (go),
        .item        (s1_item)
    );

    // Advance the header walk by one byte; an entry and a closing
    // status may both come out of the final byte.
    zlhw_parser
    #(
        .OFFSET_BITS (OFFSET_BITS)
    )
    u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .item     (s1_item),
        .res0     (res0),
        .res1     (res1),
        .push_cnt (push_cnt)
    );

    // Queue results so a stalled result side does not block the parser.
    zlhw_out_fifo u_out_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .res0         (res0),
        .res1         (res1),
        .push_cnt     (push_cnt),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head),
        .stat         (oq_stat)
    );

    assign status       = head.status;
    assign data_offset  = head.data_offset;
    assign data_size    = head.data_size;
    assign name_length  = head.name_length;
    assign name_is_utf8 = head.name_is_utf8;
    assign finished     = head.finished;

`include "zip_local_header_walker_macros.svh"

    `ZLHW_CHECK(a_level_bound, clk, rst_n, 1'b1, oq_stat.level <= zlhw_pkg::OQ_DEPTH, "queue overflow")
    `ZLHW_CHECK(a_pair_at_eof, clk, rst_n, push_cnt == 2'd2, s1_item.end_of_file, "two results off eof")
    `ZLHW_CHECK_NEXT(a_idle_empty, clk, rst_n, (oq_stat.level == 0) && (push_cnt == 2'd0), !result_valid, "phantom result")

endmodule

// ===== rtl/core/zlhw_in_stage.sv =====
// Input register of the ZIP local header walker.
// Holds one byte request until the parser takes it; uses zlhw_pkg.
module zlhw_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          file_byte,
    input  logic                end_of_file,
    input  logic                room,
    output logic                go,
    output zlhw_pkg::in_item_t  item
);

    logic               held_reg;
    logic               held_next;
    zlhw_pkg::in_item_t item_reg;
    logic               take;

    // Advance the held byte when the result queue can absorb two results.
    assign go         = held_reg && room;
    assign byte_stall = held_reg && !room;
    assign take       = byte_valid && !byte_stall;
    assign item       = item_reg;

    always_comb
    begin
        held_next = held_reg;
        if (take)
        begin
            held_next = 1'b1;
        end
        else if (go)
        begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.file_byte   <= file_byte;
            item_reg.end_of_file <= end_of_file;
        end
    end

endmodule

// ===== rtl/core/zlhw_parser.sv =====
// Header walk state machine of the ZIP local header walker.
// Consumes one byte per go pulse, emits up to two results; uses zlhw_pkg.
module zlhw_parser
#(
    parameter int OFFSET_BITS = zlhw_pkg::OFFSET_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  zlhw_pkg::in_item_t  item,
    output zlhw_pkg::result_t   res0,
    output zlhw_pkg::result_t   res1,
    output logic [1:0]          push_cnt
);

    localparam logic [OFFSET_BITS-1:0] POS_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    zlhw_pkg::phase_t        phase_reg;
    zlhw_pkg::phase_t        phase_next;
    zlhw_pkg::phase_t        phase_mid;
    logic [OFFSET_BITS-1:0]  pos_reg;
    logic [OFFSET_BITS-1:0]  pos_next;
    logic [OFFSET_BITS-1:0]  pos_inc;
    logic [OFFSET_BITS-1:0]  start_reg;
    logic [OFFSET_BITS-1:0]  start_next;
    logic [OFFSET_BITS-1:0]  stop_reg;
    logic [OFFSET_BITS-1:0]  stop_next;
    logic [OFFSET_BITS-1:0]  stop_mid;
    logic [31:0]             cnt_reg;
    logic [31:0]             cnt_next;
    logic [31:0]             cnt_inc;
    logic [31:0]             cnt_dec;
    logic [31:0]             win_reg;
    logic [31:0]             win_next;
    logic [31:0]             win_shift;
    logic [31:0]             dsize_reg;
    logic [31:0]             dsize_next;
    logic [7:0]              hdr_reg [zlhw_pkg::HDR_LEN];

    logic [31:0] sig;
    logic [15:0] flags;
    logic [15:0] method;
    logic [31:0] hsize;
    logic [15:0] nlen;
    logic [15:0] xlen;
    logic [16:0] total;
    logic        hdr_full;
    logic        sig_dir;
    logic        sig_unk;
    logic        hdr_local;
    logic        skip_last;
    logic        names_ev;
    logic        bad_method;
    logic        names_ok;
    logic        desc_mode;
    logic        entry_hdr;
    logic        data_last;
    logic        found;
    logic        dsize_cap;
    logic        dtail_last;
    logic        fin_now;
    logic        entry_any;
    logic        eof_res;
    logic        term_valid;

    zlhw_pkg::result_t ent;
    zlhw_pkg::result_t term;

    // Header fields; the last header byte arrives with the completing request.
    assign sig    = {hdr_reg[3], hdr_reg[2], hdr_reg[1], hdr_reg[0]};
    assign flags  = {hdr_reg[7], hdr_reg[6]};
    assign method = {hdr_reg[9], hdr_reg[8]};
    assign hsize  = {hdr_reg[25], hdr_reg[24], hdr_reg[23], hdr_reg[22]};
    assign nlen   = {hdr_reg[27], hdr_reg[26]};
    assign xlen   = {item.file_byte, hdr_reg[28]};
    assign total  = {1'b0, nlen} + {1'b0, xlen};

    assign pos_inc   = pos_reg + POS_ONE;
    assign cnt_inc   = cnt_reg + 32'd1;
    assign cnt_dec   = cnt_reg - 32'd1;
    assign win_shift = {item.file_byte, win_reg[31:8]};

    assign hdr_full   = (phase_reg == zlhw_pkg::PH_HEADER)
                        && (cnt_reg == 32'(zlhw_pkg::HDR_LEN - 1));
    assign sig_dir    = hdr_full
                        && ((sig == zlhw_pkg::SIG_CDIR) || (sig == zlhw_pkg::SIG_EOCD));
    assign sig_unk    = hdr_full && !sig_dir && (sig != zlhw_pkg::SIG_LOCAL);
    assign hdr_local  = hdr_full && (sig == zlhw_pkg::SIG_LOCAL);
    assign skip_last  = (phase_reg == zlhw_pkg::PH_SKIP) && (cnt_reg[31:1] == 31'd0);
    assign names_ev   = (hdr_local && (total == 17'd0)) || skip_last;
    assign bad_method = names_ev && (method != 16'd0);
    assign names_ok   = names_ev && !bad_method;
    assign desc_mode  = (flags & zlhw_pkg::FLAG_DESC) != 16'd0;
    assign entry_hdr  = names_ok && !desc_mode;
    assign data_last  = (phase_reg == zlhw_pkg::PH_DATA) && (cnt_reg[31:1] == 31'd0);
    assign found      = (phase_reg == zlhw_pkg::PH_SCAN)
                        && (cnt_reg >= 32'(zlhw_pkg::SCAN_SIG_LEN - 1))
                        && (win_shift == zlhw_pkg::SIG_DESC);
    assign dsize_cap  = (cnt_reg >= 32'(zlhw_pkg::DESC_SIZE_AT))
                        && (cnt_reg < 32'(zlhw_pkg::DESC_SIZE_AT + 4));
    assign dtail_last = (phase_reg == zlhw_pkg::PH_DTAIL)
                        && (cnt_reg == 32'(zlhw_pkg::DESC_LEN - 1));
    assign fin_now    = sig_dir || sig_unk || bad_method;

    // Next state
    always_comb
    begin
        phase_mid  = phase_reg;
        pos_next   = pos_inc;
        start_next = start_reg;
        stop_mid   = stop_reg;
        cnt_next   = cnt_reg;
        win_next   = win_reg;
        dsize_next = dsize_reg;

        case (phase_reg)
            zlhw_pkg::PH_HEADER:
            begin
                if (!hdr_full)
                begin
                    cnt_next = cnt_inc;
                end
                else if (hdr_local && (total != 17'd0))
                begin
                    phase_mid = zlhw_pkg::PH_SKIP;
                    cnt_next  = 32'(total);
                end
            end
            zlhw_pkg::PH_SKIP:
            begin
                cnt_next = cnt_dec;
            end
            zlhw_pkg::PH_DATA:
            begin
                cnt_next = cnt_dec;
                if (data_last)
                begin
                    phase_mid = zlhw_pkg::PH_HEADER;
                    cnt_next  = 32'd0;
                    stop_mid  = pos_inc;
                end
            end
            zlhw_pkg::PH_SCAN:
            begin
                win_next = win_shift;
                if (cnt_reg < 32'(zlhw_pkg::SCAN_SIG_LEN))
                begin
                    cnt_next = cnt_inc;
                end
                if (found)
                begin
                    phase_mid  = zlhw_pkg::PH_DTAIL;
                    cnt_next   = 32'(zlhw_pkg::SCAN_SIG_LEN);
                    dsize_next = 32'd0;
                end
            end
            zlhw_pkg::PH_DTAIL:
            begin
                cnt_next = cnt_inc;
                if (dsize_cap)
                begin
                    dsize_next = dsize_reg
                                 | (32'(item.file_byte) << {cnt_reg[1:0], 3'b000});
                end
                if (dtail_last)
                begin
                    phase_mid = zlhw_pkg::PH_HEADER;
                    cnt_next  = 32'd0;
                    stop_mid  = pos_inc;
                end
            end
            zlhw_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Name and extra are behind us: start the data, the descriptor scan or, for empty data, the next header.
        if (names_ok)
        begin
            start_next = pos_inc;
            if (desc_mode)
            begin
                phase_mid = zlhw_pkg::PH_SCAN;
                cnt_next  = 32'd0;
                win_next  = 32'd0;
            end
            else if (hsize == 32'd0)
            begin
                phase_mid = zlhw_pkg::PH_HEADER;
                cnt_next  = 32'd0;
                stop_mid  = pos_inc;
            end
            else
            begin
                phase_mid = zlhw_pkg::PH_DATA;
                cnt_next  = hsize;
            end
        end

        phase_next = phase_mid;
        stop_next  = stop_mid;

        // Drop all state at the end of an archive; park after a stop.
        if (item.end_of_file)
        begin
            phase_next = zlhw_pkg::PH_HEADER;
            pos_next   = '0;
            start_next = '0;
            stop_next  = '0;
            cnt_next   = 32'd0;
            win_next   = 32'd0;
            dsize_next = 32'd0;
        end
        else if (fin_now)
        begin
            phase_next = zlhw_pkg::PH_DONE;
        end
    end

    // Results
    always_comb
    begin
        entry_any = entry_hdr || dtail_last;

        ent.status       = zlhw_pkg::ST_ENTRY;
        ent.data_offset  = entry_hdr ? 32'(pos_inc) : 32'(start_reg);
        ent.data_size    = entry_hdr ? hsize : dsize_reg;
        ent.name_length  = nlen;
        ent.name_is_utf8 = (flags & zlhw_pkg::FLAG_UTF8) != 16'd0;
        ent.finished     = 1'b0;

        term.status       = zlhw_pkg::ST_SHORT;
        term.data_offset  = 32'(stop_mid);
        term.data_size    = 32'd0;
        term.name_length  = 16'd0;
        term.name_is_utf8 = 1'b0;
        term.finished     = 1'b1;
        eof_res           = 1'b0;

        if (fin_now)
        begin
            term.data_offset = 32'(stop_reg);
            if (sig_dir)
            begin
                term.status = zlhw_pkg::ST_DIR;
            end
            else if (sig_unk)
            begin
                term.status = zlhw_pkg::ST_UNKNOWN;
            end
            else
            begin
                term.status = zlhw_pkg::ST_METHOD;
            end
        end
        else if (item.end_of_file)
        begin
            case (phase_mid)
                zlhw_pkg::PH_HEADER:
                begin
                    eof_res     = 1'b1;
                    term.status = zlhw_pkg::ST_SHORT;
                end
                zlhw_pkg::PH_SKIP:
                begin
                    eof_res     = 1'b1;
                    term.status = zlhw_pkg::ST_TRUNC;
                end
                zlhw_pkg::PH_DATA:
                begin
                    eof_res          = 1'b1;
                    term.status      = zlhw_pkg::ST_SHORT;
                    term.data_offset = 32'(pos_inc);
                end
                zlhw_pkg::PH_SCAN, zlhw_pkg::PH_DTAIL:
                begin
                    eof_res     = 1'b1;
                    term.status = zlhw_pkg::ST_NODESC;
                end
                default:
                begin
                    eof_res = 1'b0;
                end
            endcase
        end

        term_valid = fin_now || eof_res;
        res0       = entry_any ? ent : term;
        res1       = term;
        push_cnt   = go ? ({1'b0, entry_any} + {1'b0, term_valid}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= zlhw_pkg::PH_HEADER;
            pos_reg   <= '0;
            start_reg <= '0;
            stop_reg  <= '0;
            cnt_reg   <= 32'd0;
            win_reg   <= 32'd0;
            dsize_reg <= 32'd0;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            stop_reg  <= stop_next;
            cnt_reg   <= cnt_next;
            win_reg   <= win_next;
            dsize_reg <= dsize_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && (phase_reg == zlhw_pkg::PH_HEADER))
        begin
            hdr_reg[cnt_reg[zlhw_pkg::HDR_AW-1:0]] <= item.file_byte;
        end
    end

endmodule

// ===== rtl/core/zlhw_out_fifo.sv =====
// Result queue of the ZIP local header walker.
// Takes up to two results per cycle, gives one while result_stall is low; uses zlhw_pkg.
module zlhw_out_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  zlhw_pkg::result_t   res0,
    input  zlhw_pkg::result_t   res1,
    input  logic [1:0]          push_cnt,
    output logic                result_valid,
    input  logic                result_stall,
    output zlhw_pkg::result_t   head,
    output zlhw_pkg::oq_stat_t  stat
);

    localparam logic [zlhw_pkg::OQ_AW-1:0] PTR_ONE = {{(zlhw_pkg::OQ_AW-1){1'b0}}, 1'b1};

    zlhw_pkg::result_t              q_reg [zlhw_pkg::OQ_DEPTH];
    logic [zlhw_pkg::OQ_AW-1:0]     wr_reg;
    logic [zlhw_pkg::OQ_AW-1:0]     wr_next;
    logic [zlhw_pkg::OQ_AW-1:0]     rd_reg;
    logic [zlhw_pkg::OQ_AW-1:0]     rd_next;
    logic [zlhw_pkg::OQ_AW:0]       level_reg;
    logic [zlhw_pkg::OQ_AW:0]       level_next;
    logic                           pop;

    assign result_valid = level_reg != '0;
    assign pop          = result_valid && !result_stall;
    assign head         = q_reg[rd_reg];
    assign stat.level   = level_reg;
    // Leave space for a full pair of results.
    assign stat.room    = level_reg <= (zlhw_pkg::OQ_AW + 1)'(zlhw_pkg::OQ_DEPTH - 2);

    always_comb
    begin
        wr_next    = wr_reg + zlhw_pkg::OQ_AW'(push_cnt);
        rd_next    = pop ? rd_reg + PTR_ONE : rd_reg;
        level_next = level_reg + (zlhw_pkg::OQ_AW + 1)'(push_cnt)
                     - {{zlhw_pkg::OQ_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_reg[wr_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            q_reg[wr_reg + PTR_ONE] <= res1;
        end
    end

endmodule

// ===== verif/zip_local_header_walker_checker.sv =====
// Checker for the ZIP local header walker: tracks the byte and result channels,
// predicts each result from the accepted byte requests and compares field by field.
// Depends on zlhw_pkg.
module zip_local_header_walker_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  file_byte,
    input  logic        end_of_file,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [2:0]  status,
    input  logic [31:0] data_offset,
    input  logic [31:0] data_size,
    input  logic [15:0] name_length,
    input  logic        name_is_utf8,
    input  logic        finished,
    output int          fail_count,
    output int          results_due
);
    import zlhw_pkg::*;

    phase_t      walk_phase;
    logic [31:0] walk_pos;
    logic [31:0] walk_count;
    logic [31:0] stop_pos;
    logic [31:0] data_start;
    logic [31:0] desc_size;
    logic [31:0] sig_win;
    logic [7:0]  hdr [HDR_LEN];
    result_t     report_q [$];

    function automatic logic [15:0] hdr16(int i);
        return {hdr[i + 1], hdr[i]};
    endfunction

    function automatic logic [31:0] hdr32(int i);
        return {hdr16(i + 2), hdr16(i)};
    endfunction

    function automatic void post_report(logic [2:0] st, logic [31:0] off, logic [31:0] size,
                                        logic [15:0] nlen, logic utf8, logic fin);
        result_t r;
        r.status       = st;
        r.data_offset  = off;
        r.data_size    = size;
        r.name_length  = nlen;
        r.name_is_utf8 = utf8;
        r.finished     = fin;
        report_q.push_back(r);
    endfunction

    function automatic void post_entry(logic [31:0] size);
        post_report(ST_ENTRY, data_start, size, hdr16(26), (hdr16(6) & FLAG_UTF8) != 0, 1'b0);
    endfunction

    function automatic void rewind(logic [31:0] next);
        walk_phase = PH_HEADER;
        walk_count = 0;
        stop_pos   = next;
    endfunction

    function automatic void clear_walk();
        walk_phase = PH_HEADER;
        walk_pos   = 0;
        walk_count = 0;
        stop_pos   = 0;
        data_start = 0;
        desc_size  = 0;
        sig_win    = 0;
        for (int i = 0; i < HDR_LEN; i++)
            hdr[i] = 8'h00;
    endfunction

    // Name and extra are behind us; returns 1 when the archive stops here.
    function automatic bit close_names(logic [31:0] next);
        if (hdr16(8) != 0)
        begin
            post_report(ST_METHOD, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
            return 1'b1;
        end
        data_start = next;
        if ((hdr16(6) & FLAG_DESC) != 0)
        begin
            walk_phase = PH_SCAN;
            walk_count = 0;
            sig_win    = 0;
            return 1'b0;
        end
        post_entry(hdr32(22));
        walk_count = hdr32(22);
        if (walk_count == 0)
            rewind(next);
        else
            walk_phase = PH_DATA;
        return 1'b0;
    endfunction

    function automatic void walk_byte(logic [7:0] b, logic eof);
        logic [31:0] next;
        logic [31:0] sig;
        logic [31:0] total;
        bit          stopped;
        next    = walk_pos + 1;
        stopped = 1'b0;
        case (walk_phase)
            PH_HEADER:
            begin
                if (walk_count < HDR_LEN)
                    hdr[walk_count] = b;
                walk_count++;
                if (walk_count >= HDR_LEN)
                begin
                    sig = hdr32(0);
                    if (sig == SIG_CDIR || sig == SIG_EOCD)
                    begin
                        post_report(ST_DIR, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
                        stopped = 1'b1;
                    end
                    else if (sig != SIG_LOCAL)
                    begin
                        post_report(ST_UNKNOWN, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
                        stopped = 1'b1;
                    end
                    else
                    begin
                        total = 32'(hdr16(26)) + 32'(hdr16(28));
                        if (total != 0)
                        begin
                            walk_phase = PH_SKIP;
                            walk_count = total;
                        end
                        else
                            stopped = close_names(next);
                    end
                end
            end
            PH_SKIP:
            begin
                if (walk_count > 0)
                    walk_count--;
                if (walk_count == 0)
                    stopped = close_names(next);
            end
            PH_DATA:
            begin
                if (walk_count > 0)
                    walk_count--;
                if (walk_count == 0)
                    rewind(next);
            end
            PH_SCAN:
            begin
                sig_win = {b, sig_win[31:8]};
                if (walk_count < SCAN_SIG_LEN)
                    walk_count++;
                if (walk_count >= SCAN_SIG_LEN && sig_win == SIG_DESC)
                begin
                    walk_phase = PH_DTAIL;
                    walk_count = SCAN_SIG_LEN;
                    desc_size  = 0;
                end
            end
            PH_DTAIL:
            begin
                if (walk_count >= DESC_SIZE_AT && walk_count < DESC_SIZE_AT + 4)
                    desc_size = desc_size | (32'(b) << (8 * (walk_count - DESC_SIZE_AT)));
                walk_count++;
                if (walk_count >= DESC_LEN)
                begin
                    post_entry(desc_size);
                    rewind(next);
                end
            end
            default:
            begin
            end
        endcase

        walk_pos = next;

        if (eof && !stopped)
        begin
            case (walk_phase)
                PH_HEADER: post_report(ST_SHORT, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
                PH_SKIP:   post_report(ST_TRUNC, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
                PH_DATA:   post_report(ST_SHORT, next, 32'd0, 16'd0, 1'b0, 1'b1);
                PH_SCAN,
                PH_DTAIL:  post_report(ST_NODESC, stop_pos, 32'd0, 16'd0, 1'b0, 1'b1);
                default:
                begin
                end
            endcase
        end

        // every archive restarts at offset 0; after a stop, drop bytes until its end
        if (eof)
            clear_walk();
        else if (stopped)
            walk_phase = PH_DONE;
    endfunction

    function automatic void check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            clear_walk();
            report_q.delete();
            fail_count = 0;
            results_due <= 0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                walk_byte(file_byte, end_of_file);
            if (result_valid && !result_stall)
            begin
                if (report_q.size() == 0)
                begin
                    $error("result: none expected, got status %0d at 0x%0h",
                           status, data_offset);
                    fail_count++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("data_offset", want.data_offset, data_offset);
                    check_field("data_size", want.data_size, data_size);
                    check_field("name_length", 32'(want.name_length), 32'(name_length));
                    check_field("name_is_utf8", 32'(want.name_is_utf8), 32'(name_is_utf8));
                    check_field("finished", 32'(want.finished), 32'(finished));
                end
            end
            results_due <= report_q.size();
        end
    end

endmodule

// ===== verif/zip_local_header_walker_tb.sv =====
// Top of the ZIP local header walker testbench: clock, reset, archive stimulus,
// result-side stalls and the verdict. Depends on zlhw_pkg, the walker RTL and
// zip_local_header_walker_checker.
module zip_local_header_walker_tb;
    import zlhw_pkg::*;

    localparam logic [15:0] METHOD_NONE     = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE  = 16'd8;
    localparam int          IDLE_PCT        = 27;
    localparam int          HOLD_OFF_CYCLES = 400;
    localparam int          RANDOM_BYTES    = 350;
    localparam int          MIN_ARCHIVES    = 4;
    localparam int          DRAIN_CYCLES    = 10;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic        byte_stall;
    logic [7:0]  file_byte    = 8'h00;
    logic        end_of_file  = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [2:0]  status;
    logic [31:0] data_offset;
    logic [31:0] data_size;
    logic [15:0] name_length;
    logic        name_is_utf8;
    logic        finished;
    int          fail_count;
    int          results_due;

    // Idle and stall rates; the stimulus drops both to zero for a stretch.
    int          idle_pct    = IDLE_PCT;
    int          stall_pct   = IDLE_PCT;
    bit          hold_off_go = 1'b0;

    // Archive under construction, sent whole with end_of_file on its last byte.
    logic [7:0]  zip_bytes [$];
    int          bytes_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    zip_local_header_walker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .file_byte    (file_byte),
        .end_of_file  (end_of_file),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .data_offset  (data_offset),
        .data_size    (data_size),
        .name_length  (name_length),
        .name_is_utf8 (name_is_utf8),
        .finished     (finished)
    );

    zip_local_header_walker_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .file_byte    (file_byte),
        .end_of_file  (end_of_file),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .data_offset  (data_offset),
        .data_size    (data_size),
        .name_length  (name_length),
        .name_is_utf8 (name_is_utf8),
        .finished     (finished),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // ---------------------------------------------------------------------
    // Archive builders: append little-endian fields and filler to zip_bytes.
    // ---------------------------------------------------------------------
    function automatic void add_le(logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            zip_bytes.push_back(v[8 * i +: 8]);
    endfunction

    function automatic void add_noise(int n);
        repeat (n)
            zip_bytes.push_back(8'($urandom));
    endfunction

    // 30-byte local header layout: signature, version, flags, method,
    // time/date/CRC, compressed size, size, name length, extra length.
    function automatic void add_header(logic [31:0] sig, logic [15:0] flags,
                                       logic [15:0] method, logic [31:0] size,
                                       logic [15:0] nlen, logic [15:0] xlen);
        add_le(sig, 4);
        add_noise(2);
        add_le(flags, 2);
        add_le(method, 2);
        add_noise(12);
        add_le(size, 4);
        add_le(nlen, 2);
        add_le(xlen, 2);
    endfunction

    // Data descriptor: signature, CRC, size at byte 8, trailing size word.
    function automatic void add_descriptor(logic [31:0] size);
        add_le(SIG_DESC, 4);
        add_noise(4);
        add_le(size, 4);
        add_noise(4);
    endfunction

    // Complete stored entry; with the descriptor flag the header size is junk
    // and the real length follows the data in a descriptor.
    function automatic void add_entry(logic [15:0] flags, int nlen, int xlen, int dlen);
        if ((flags & FLAG_DESC) != 0)
        begin
            add_header(SIG_LOCAL, flags, METHOD_NONE, $urandom, 16'(nlen), 16'(xlen));
            add_noise(nlen + xlen + dlen);
            add_descriptor(32'(dlen));
        end
        else
        begin
            add_header(SIG_LOCAL, flags, METHOD_NONE, 32'(dlen), 16'(nlen), 16'(xlen));
            add_noise(nlen + xlen + dlen);
        end
    endfunction

    function automatic logic [15:0] rand_flags(bit desc);
        logic [15:0] f;
        f    = 16'($urandom_range(0, 65535));
        f[3] = desc;
        return f;
    endfunction

    // Mostly well-formed archives (a few entries, then some way to stop),
    // with pure noise now and then.
    function automatic void make_random_archive();
        int          ending;
        int          nlen;
        int          xlen;
        int          n;
        logic [31:0] size;
        if ($urandom_range(0, 99) < 8)
        begin
            add_noise($urandom_range(1, 60));
            return;
        end
        repeat ($urandom_range(0, 3))
            add_entry(rand_flags($urandom_range(0, 99) < 30),
                      $urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 12));
        ending = $urandom_range(0, 7);
        case (ending)
            0:
            begin
                add_header(SIG_CDIR, rand_flags(0), 16'($urandom), $urandom,
                           16'($urandom), 16'($urandom));
                add_noise($urandom_range(0, 8));
            end
            1:
            begin
                // EOCD record is short; sometimes too short to fill a header
                add_le(SIG_EOCD, 4);
                add_noise($urandom_range(18, 30));
            end
            2:
            begin
                add_header($urandom, rand_flags(0), 16'($urandom), $urandom,
                           16'($urandom), 16'($urandom));
                add_noise($urandom_range(0, 4));
            end
            3:
                add_noise($urandom_range(0, 29));
            4:
            begin
                nlen = $urandom_range(0, 4);
                xlen = $urandom_range(0, 4);
                add_header(SIG_LOCAL, rand_flags($urandom_range(0, 1)),
                           16'($urandom_range(1, 65535)), $urandom_range(0, 9),
                           16'(nlen), 16'(xlen));
                add_noise(nlen + xlen + $urandom_range(0, 6));
            end
            5:
            begin
                nlen = $urandom_range(1, 20);
                xlen = $urandom_range(0, 20);
                add_header(SIG_LOCAL, rand_flags($urandom_range(0, 1)),
                           ($urandom_range(0, 1) != 0) ? METHOD_NONE : METHOD_DEFLATE,
                           $urandom_range(0, 9), 16'(nlen), 16'(xlen));
                add_noise($urandom_range(0, nlen + xlen - 1));
            end
            6:
            begin
                nlen = $urandom_range(0, 3);
                xlen = $urandom_range(0, 3);
                size = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(2, 40);
                add_header(SIG_LOCAL, rand_flags(0), METHOD_NONE, size,
                           16'(nlen), 16'(xlen));
                n = (size > 41) ? $urandom_range(0, 40) : $urandom_range(0, size - 1);
                add_noise(nlen + xlen + n);
            end
            default:
            begin
                nlen = $urandom_range(0, 3);
                xlen = $urandom_range(0, 3);
                add_header(SIG_LOCAL, rand_flags(1), METHOD_NONE, $urandom,
                           16'(nlen), 16'(xlen));
                add_noise(nlen + xlen + $urandom_range(0, 10));
                if ($urandom_range(0, 1) != 0)
                begin
                    add_le(SIG_DESC, 4);
                    add_noise($urandom_range(0, 11));
                end
            end
        endcase
        if (zip_bytes.size() == 0)
            add_noise(1);
    endfunction

    // Drive one byte request per archive byte; hold each one until accepted.
    task automatic send_archive();
        int n;
        n = zip_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            while ($urandom_range(0, 99) < idle_pct)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid  <= 1'b1;
            file_byte   <= zip_bytes[i];
            end_of_file <= (i == n - 1);
            do
                @(posedge clk);
            while (byte_stall);
        end
        bytes_sent += n;
        zip_bytes.delete();
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stalls, plus one long hold-off counted here so the
    // result queue fills and the walker stalls byte requests.
    // ---------------------------------------------------------------------
    initial
    begin : receiver
        int hold_left;
        bit hold_used;
        hold_left = 0;
        hold_used = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
                result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus: reset, directed archives, random archives, drain, verdict.
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int archives;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Hold off the result side while the directed archives pile up results.
        hold_off_go <= 1'b1;

        // Stored UTF-8 entry with name and extra, then an EOCD record.
        add_entry(FLAG_UTF8, 3, 2, 4);
        add_header(SIG_EOCD, 16'h0000, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        send_archive();

        // Empty entry ending on the final byte: entry and short tail together.
        add_header(SIG_LOCAL, 16'h0000, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        send_archive();

        // Central directory first, all-ones fields; drop the bytes after it.
        add_header(SIG_CDIR, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        add_noise(5);
        send_archive();

        // Unknown signatures: all ones, then all zeros.
        repeat (HDR_LEN) zip_bytes.push_back(8'hFF);
        send_archive();
        repeat (HDR_LEN) zip_bytes.push_back(8'h00);
        send_archive();

        // One-byte archive, then an entry followed by a 29-byte tail.
        zip_bytes.push_back(8'h50);
        send_archive();
        add_entry(16'h0000, 1, 1, 2);
        add_noise(HDR_LEN - 1);
        send_archive();

        // Deflated entry: bad method once the name is skipped.
        add_header(SIG_LOCAL, 16'h0000, METHOD_DEFLATE, 32'd4, 16'd2, 16'd0);
        add_noise(6);
        send_archive();

        // Bad method with maximal name and extra cut off: truncation wins.
        add_header(SIG_LOCAL, 16'h0000, METHOD_DEFLATE, 32'd0, 16'hFFFF, 16'hFFFF);
        add_noise(5);
        send_archive();

        // Name expected but archive ends on the last header byte.
        add_header(SIG_LOCAL, 16'h0000, METHOD_NONE, 32'd0, 16'd2, 16'd0);
        send_archive();

        // Maximal size, data cut short: short tail at the archive length.
        add_header(SIG_LOCAL, FLAG_UTF8, METHOD_NONE, 32'hFFFF_FFFF, 16'd0, 16'd0);
        add_noise(3);
        send_archive();

        // Descriptor entry with an all-ones size, then a stored entry and a directory.
        add_header(SIG_LOCAL, FLAG_DESC | FLAG_UTF8, METHOD_NONE, 32'd0, 16'd2, 16'd1);
        add_noise(8);
        add_descriptor(32'hFFFF_FFFF);
        add_entry(16'h0000, 0, 0, 1);
        add_header(SIG_CDIR, 16'h0000, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        send_archive();

        // Descriptor never shows up.
        add_header(SIG_LOCAL, FLAG_DESC, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        add_noise(6);
        send_archive();

        // Descriptor signature found but the archive ends inside it.
        add_header(SIG_LOCAL, FLAG_DESC, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        add_le(SIG_DESC, 4);
        add_noise(7);
        send_archive();

        // Descriptor right after the header, completed on the final byte.
        add_header(SIG_LOCAL, FLAG_DESC, METHOD_NONE, 32'd0, 16'd0, 16'd0);
        add_descriptor(32'd0);
        send_archive();

        // Two one-byte entries and a short tail.
        add_entry(16'h0000, 0, 0, 1);
        add_entry(16'h0000, 0, 0, 1);
        add_noise(10);
        send_archive();

        // Random archives: run without idles or stalls for archives 1 and 2.
        archives   = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES || archives < MIN_ARCHIVES)
        begin
            idle_pct  = (archives >= 1 && archives < 3) ? 0 : IDLE_PCT;
            stall_pct = idle_pct;
            make_random_archive();
            send_archive();
            archives++;
        end
        byte_valid <= 1'b0;

        // Drain: let the last request reach the checker, wait out the results.
        repeat (2) @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("zip_local_header_walker regression: pass");
        else
            $display("zip_local_header_walker regression: fail");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("zip_local_header_walker regression: fail");
        $finish;
    end

endmodule
